### rtl/fsnp_pkg.sv
// shared types and constants for the format string number printer
`timescale 1ns / 1ps
`default_nettype none
package fsnp_pkg;

  localparam int MAX_WIDTH = 48;
  localparam int WIDTH_BITS = 6;
  localparam int DIG_BITS = 4;
  localparam int NDIG_BITS = 4;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_LOW_D = 8'h64;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_LOW_P = 8'h70;

  typedef enum logic [1:0] {
    PK_SPACE = 2'd0,
    PK_ZERO = 2'd1,
    PK_LEFT = 2'd2,
    PK_UNUSED = 2'd3
  } pad_kind_t;

  // character source selection for the emit mux
  typedef enum logic [2:0] {
    EM_LIT,
    EM_PAD,
    EM_DIGIT,
    EM_MINUS,
    EM_ZERO,
    EM_X,
    EM_SPACE
  } emit_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture argument, start digit extraction
    logic hex;
    logic negate;
    logic step;        // extract one digit
    logic pop;         // drop the most significant stored digit
    emit_sel_t sel;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;        // magnitude is zero (after at least one digit)
    logic [NDIG_BITS-1:0] ndig;
  } dp_stat_t;

  function automatic logic [7:0] hex_char(input logic [DIG_BITS-1:0] d);
    hex_char = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction

endpackage
`default_nettype wire

### rtl/fsnp_datapath.sv
// number datapath: digit extraction by ten or sixteen and output character mux
`timescale 1ns / 1ps
`default_nettype none
module fsnp_datapath (
  input  wire logic clk,
  input  wire fsnp_pkg::dp_cmd_t cmd,
  input  wire logic [31:0] arg_value,
  input  wire logic [7:0] lit,
  input  wire logic [7:0] pad_char,
  output fsnp_pkg::dp_stat_t stat,
  output logic [7:0] char_out
);

  logic [31:0] mag;
  logic [3:0] digs [12];
  logic [fsnp_pkg::NDIG_BITS-1:0] ndig;
  logic hex;
  logic started;
  logic [31:0] quot;
  logic [3:0] rem;
  logic [63:0] prod;

  // divide by ten with a reciprocal multiply, quotient is product >> 35; by sixteen with a shift in hex mode
  always_comb begin
    prod = {32'd0, mag} * 64'hCCCCCCCD;
    quot = prod[63:32] >> 3;
    rem = 4'(mag - quot * 32'd10);
    if (hex) begin
      quot = mag >> 4;
      rem = mag[3:0];
    end
  end

  // digits are stored least significant first, emitted from the top down
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= cmd.negate ? (32'd0 - arg_value) : arg_value;
      hex <= cmd.hex;
      ndig <= '0;
      started <= 1'b0;
    end else if (cmd.step) begin
      digs[ndig] <= rem;
      mag <= quot;
      ndig <= ndig + 1'b1;
      started <= 1'b1;
    end else if (cmd.pop) begin
      ndig <= ndig - 1'b1;
    end
  end

  assign stat.done = started && (mag == 32'd0);
  assign stat.ndig = ndig;

  always_comb begin
    unique case (cmd.sel)
      fsnp_pkg::EM_LIT:   char_out = lit;
      fsnp_pkg::EM_PAD:   char_out = pad_char;
      fsnp_pkg::EM_DIGIT: char_out = fsnp_pkg::hex_char(digs[ndig - 1'b1]);
      fsnp_pkg::EM_MINUS: char_out = fsnp_pkg::CH_MINUS;
      fsnp_pkg::EM_ZERO:  char_out = fsnp_pkg::CH_ZERO;
      fsnp_pkg::EM_X:     char_out = fsnp_pkg::CH_LOW_X;
      default:            char_out = fsnp_pkg::CH_SPACE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/fsnp_control.sv
// controller: format parser and emission sequencer
`timescale 1ns / 1ps
`default_nettype none
module fsnp_control (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] symbol,
  input  wire logic [31:0] arg_value,
  output logic out_valid,
  input  wire logic out_stall,
  output logic last,
  output fsnp_pkg::dp_cmd_t cmd,
  input  wire fsnp_pkg::dp_stat_t stat,
  output logic [7:0] lit,
  output logic [7:0] pad_char,
  output logic [31:0] arg_hold
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXTRACT, S_PRE, S_PREPAD, S_DIGITS, S_POSTPAD, S_LIT
  } state_t;

  typedef enum logic [1:0] {
    PH_SCAN, PH_FLAGS, PH_WIDTH, PH_LENGTH
  } phase_t;

  state_t state;
  phase_t phase;
  fsnp_pkg::pad_kind_t pad_kind;
  logic [fsnp_pkg::WIDTH_BITS-1:0] field_width;
  logic [fsnp_pkg::WIDTH_BITS-1:0] pad_left;
  logic [1:0] pre_left;       // prefix characters to emit: minus, or 0 then x
  logic is_ptr;
  logic use_left;
  logic [9:0] wsum;

  logic acc;
  logic emit;
  logic [7:0] c;
  logic is_digit;
  logic is_len;

  assign acc = in_valid && !in_stall;
  assign emit = out_valid && !out_stall;
  assign c = symbol;
  assign is_digit = (c >= fsnp_pkg::CH_ZERO) && (c <= fsnp_pkg::CH_NINE);
  assign is_len = (c == 8'h68) || (c == 8'h6c) || (c == 8'h4c) || (c == 8'h6a) ||
                  (c == 8'h7a) || (c == 8'h74);
  assign in_stall = (state != S_IDLE);
  assign pad_char = (is_ptr || pad_kind == fsnp_pkg::PK_ZERO) ? fsnp_pkg::CH_ZERO
                                                              : fsnp_pkg::CH_SPACE;
  assign wsum = {4'b0, field_width} * 10'd10 + 10'(c - fsnp_pkg::CH_ZERO);

  // command decode
  always_comb begin
    cmd = '0;
    cmd.sel = fsnp_pkg::EM_LIT;
    unique case (state)
      S_EXTRACT: cmd.step = !stat.done;
      S_PRE: cmd.sel = is_ptr ? ((pre_left == 2'd2) ? fsnp_pkg::EM_ZERO : fsnp_pkg::EM_X)
                              : fsnp_pkg::EM_MINUS;
      S_PREPAD: cmd.sel = fsnp_pkg::EM_PAD;
      S_DIGITS: begin
        cmd.sel = fsnp_pkg::EM_DIGIT;
        cmd.pop = emit;
      end
      S_POSTPAD: cmd.sel = fsnp_pkg::EM_SPACE;
      default: cmd.sel = fsnp_pkg::EM_LIT;
    endcase
    // a conversion can end any parse phase, so load on every item past the percent
    if (state == S_IDLE && acc && phase != PH_SCAN) begin
      cmd.load = 1'b1;
      cmd.hex = (c == fsnp_pkg::CH_LOW_X) || (c == fsnp_pkg::CH_LOW_P);
      cmd.negate = (c == fsnp_pkg::CH_LOW_D) && arg_value[31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_SCAN;
      pad_kind <= fsnp_pkg::PK_SPACE;
      field_width <= '0;
      out_valid <= 1'b0;
      last <= 1'b0;
      is_ptr <= 1'b0;
      pre_left <= '0;
      pad_left <= '0;
      use_left <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            phase_t ph;
            ph = phase;
            if (ph == PH_FLAGS) begin
              if (c == fsnp_pkg::CH_ZERO) pad_kind <= fsnp_pkg::PK_ZERO;
              else if (c == fsnp_pkg::CH_MINUS) pad_kind <= fsnp_pkg::PK_LEFT;
              if (c == fsnp_pkg::CH_ZERO || c == fsnp_pkg::CH_MINUS ||
                  c == fsnp_pkg::CH_SPACE || c == fsnp_pkg::CH_PLUS) ph = PH_SCAN;
              else ph = PH_WIDTH;
              if (ph == PH_SCAN) phase <= PH_FLAGS;
            end
            if (ph == PH_WIDTH) begin
              if (is_digit) begin
                field_width <= (wsum > 10'(fsnp_pkg::MAX_WIDTH)) ?
                               6'(fsnp_pkg::MAX_WIDTH) : wsum[5:0];
                phase <= PH_WIDTH;
                ph = PH_SCAN;
              end else ph = PH_LENGTH;
            end
            if (ph == PH_LENGTH && phase != PH_SCAN) begin
              if (is_len) begin
                phase <= PH_LENGTH;
              end else begin
                phase <= PH_SCAN;
                if (c == fsnp_pkg::CH_LOW_D || c == fsnp_pkg::CH_LOW_U ||
                    c == fsnp_pkg::CH_LOW_X || c == fsnp_pkg::CH_LOW_P) begin
                  is_ptr <= (c == fsnp_pkg::CH_LOW_P);
                  use_left <= (c != fsnp_pkg::CH_LOW_P) && (pad_kind == fsnp_pkg::PK_LEFT);
                  pre_left <= (c == fsnp_pkg::CH_LOW_P) ? 2'd2 :
                              (c == fsnp_pkg::CH_LOW_D && arg_value[31]) ? 2'd1 : 2'd0;
                  state <= S_EXTRACT;
                end else begin
                  lit <= c;
                  last <= 1'b1;
                  out_valid <= 1'b1;
                  state <= S_LIT;
                end
              end
            end else if (phase == PH_SCAN) begin
              if (c == fsnp_pkg::CH_PERCENT) begin
                phase <= PH_FLAGS;
                pad_kind <= fsnp_pkg::PK_SPACE;
                field_width <= '0;
              end else begin
                lit <= c;
                last <= 1'b1;
                out_valid <= 1'b1;
                state <= S_LIT;
              end
            end
          end
        end
        S_LIT: if (emit) begin
          out_valid <= 1'b0;
          last <= 1'b0;
          state <= S_IDLE;
        end
        S_EXTRACT: if (stat.done) begin
          logic [fsnp_pkg::WIDTH_BITS-1:0] w;
          w = is_ptr ? 6'd8 : field_width;
          pad_left <= (w > 6'(stat.ndig)) ? (w - 6'(stat.ndig)) : '0;
          out_valid <= 1'b1;
          last <= 1'b0;
          if (pre_left != 2'd0) state <= S_PRE;
          else if (!use_left && w > 6'(stat.ndig)) state <= S_PREPAD;
          else begin
            state <= S_DIGITS;
            last <= (stat.ndig == 4'd1) && !(use_left && w > 6'(stat.ndig));
          end
        end
        S_PRE: if (emit) begin
          pre_left <= pre_left - 2'd1;
          if (pre_left == 2'd1 || (is_ptr && pre_left == 2'd1)) begin
            if (!use_left && pad_left != '0) state <= S_PREPAD;
            else begin
              state <= S_DIGITS;
              last <= (stat.ndig == 4'd1) && !(use_left && pad_left != '0);
            end
          end
        end
        S_PREPAD: if (emit) begin
          pad_left <= pad_left - 1'b1;
          if (pad_left == 6'd1) begin
            state <= S_DIGITS;
            last <= (stat.ndig == 4'd1);
          end
        end
        S_DIGITS: if (emit) begin
          if (stat.ndig == 4'd1) begin
            if (use_left && pad_left != '0) begin
              state <= S_POSTPAD;
              last <= (pad_left == 6'd1);
            end else begin
              out_valid <= 1'b0;
              last <= 1'b0;
              state <= S_IDLE;
            end
          end else begin
            last <= (stat.ndig == 4'd2) && !(use_left && pad_left != '0);
          end
        end
        S_POSTPAD: if (emit) begin
          pad_left <= pad_left - 1'b1;
          last <= (pad_left == 6'd2);
          if (pad_left == 6'd1) begin
            out_valid <= 1'b0;
            last <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign arg_hold = arg_value;

endmodule
`default_nettype wire

### rtl/format_string_number_printer_unit.sv
// top level of the format string number printer
// Takes one format character per item with a 32-bit argument and emits text, one
// character per output item, with last marking the final character of each input
// item. Literals and '%%' emit one character. A d/u conversion extracts its decimal
// digits (up to ten) in the divide-by-ten digit unit, x and p their hex digits, then
// the unit emits the conversion's characters (up to 49). Flag, width and length
// characters emit nothing and cause no stall. Input is stalled from the cycle after
// an item that prints is taken until its last character leaves.
`timescale 1ns / 1ps
`default_nettype none
module format_string_number_printer_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] symbol,
  input  wire logic [31:0] arg_value,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [7:0] out_char,
  output logic last
);

  fsnp_pkg::dp_cmd_t cmd;
  fsnp_pkg::dp_stat_t stat;
  logic [7:0] lit;
  logic [7:0] pad_char;
  logic [31:0] arg_hold;

  fsnp_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .symbol(symbol), .arg_value(arg_value), .out_valid(out_valid),
    .out_stall(out_stall), .last(last), .cmd(cmd), .stat(stat),
    .lit(lit), .pad_char(pad_char), .arg_hold(arg_hold)
  );

  fsnp_datapath u_dp (
    .clk(clk), .cmd(cmd), .arg_value(arg_hold), .lit(lit),
    .pad_char(pad_char), .stat(stat), .char_out(out_char)
  );

endmodule
`default_nettype wire

### rtl/fsnp_checker.sv
// port checker for the format string number printer
`timescale 1ns / 1ps
`default_nettype none
module fsnp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [7:0] out_char,
  input wire logic last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
    else $error("stalled output item changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while output pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid)
    else $error("output continued after last");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind format_string_number_printer_unit fsnp_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_char(out_char), .last(last)
);
`default_nettype wire

### test/format_string_number_printer_unit_test.sv
// format string number printer testbench: directed table, stall burst, random format strings
`timescale 1ns / 1ps
`default_nettype none
module format_string_number_printer_unit_test;

  typedef enum logic [2:0] {
    PH_SCAN = 3'd0,
    PH_FLAGS = 3'd1,
    PH_WIDTH = 3'd2,
    PH_LENGTH = 3'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic lst;
  } text_char_t;

  typedef struct {
    logic [7:0] symbol;
    logic [31:0] arg;
    string text; // expected text typed in, empty means use the predictor
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] symbol = 8'd0;
  logic [31:0] arg_value = 32'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_char;
  logic last;

  format_string_number_printer_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .symbol(symbol), .arg_value(arg_value), .out_valid(out_valid),
    .out_stall(out_stall), .out_char(out_char), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  phase_t fmt_phase = PH_SCAN;
  fsnp_pkg::pad_kind_t fmt_pad = fsnp_pkg::PK_SPACE;
  int unsigned fmt_width = 0;

  text_char_t expected_text[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;
  int quiet_cycles = 0;

  task automatic report(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void put_number(ref logic [7:0] buf_q[$], input logic [31:0] v,
                                     input bit hex, input fsnp_pkg::pad_kind_t kind,
                                     input int unsigned width);
    logic [7:0] dig[$];
    int unsigned padn;
    logic [7:0] padc;
    padc = (kind == fsnp_pkg::PK_ZERO) ? fsnp_pkg::CH_ZERO : fsnp_pkg::CH_SPACE;
    if (v == 0) dig.push_front(fsnp_pkg::CH_ZERO);
    while (v != 0) begin
      if (hex) begin
        dig.push_front((v[3:0] < 10) ? 8'(fsnp_pkg::CH_ZERO + v[3:0])
                                     : 8'(8'h57 + v[3:0]));
        v = v >> 4;
      end else begin
        dig.push_front(8'(fsnp_pkg::CH_ZERO + v % 10));
        v = v / 10;
      end
    end
    padn = (width > dig.size()) ? width - dig.size() : 0;
    if (kind != fsnp_pkg::PK_LEFT) repeat (padn) buf_q.push_back(padc);
    foreach (dig[i]) buf_q.push_back(dig[i]);
    if (kind == fsnp_pkg::PK_LEFT) repeat (padn) buf_q.push_back(fsnp_pkg::CH_SPACE);
  endfunction

  // advance the format state by one symbol and return the text it prints
  function automatic void format_symbol(input logic [7:0] c, input logic [31:0] a,
                                        ref logic [7:0] buf_q[$]);
    int unsigned w;
    fsnp_pkg::pad_kind_t kind;
    buf_q = {};
    if (fmt_phase == PH_FLAGS) begin
      if (c == fsnp_pkg::CH_ZERO) begin fmt_pad = fsnp_pkg::PK_ZERO; return; end
      if (c == fsnp_pkg::CH_MINUS) begin fmt_pad = fsnp_pkg::PK_LEFT; return; end
      if (c == fsnp_pkg::CH_SPACE || c == fsnp_pkg::CH_PLUS) return;
      fmt_phase = PH_WIDTH;
    end
    if (fmt_phase == PH_WIDTH) begin
      if (c >= fsnp_pkg::CH_ZERO && c <= fsnp_pkg::CH_NINE) begin
        w = fmt_width * 10 + (c - fsnp_pkg::CH_ZERO);
        fmt_width = (w > fsnp_pkg::MAX_WIDTH) ? fsnp_pkg::MAX_WIDTH : w;
        return;
      end
      fmt_phase = PH_LENGTH;
    end
    if (fmt_phase == PH_LENGTH) begin
      if (c inside {"h", "l", "L", "j", "z", "t"}) return;
      kind = (fmt_pad == fsnp_pkg::PK_UNUSED) ? fsnp_pkg::PK_SPACE : fmt_pad;
      case (c)
        fsnp_pkg::CH_LOW_D: begin
          if (a[31]) begin
            buf_q.push_back(fsnp_pkg::CH_MINUS);
            put_number(buf_q, -a, 1'b0, kind, fmt_width);
          end else put_number(buf_q, a, 1'b0, kind, fmt_width);
        end
        fsnp_pkg::CH_LOW_U: put_number(buf_q, a, 1'b0, kind, fmt_width);
        fsnp_pkg::CH_LOW_X: put_number(buf_q, a, 1'b1, kind, fmt_width);
        fsnp_pkg::CH_LOW_P: begin
          buf_q.push_back(fsnp_pkg::CH_ZERO);
          buf_q.push_back(fsnp_pkg::CH_LOW_X);
          put_number(buf_q, a, 1'b1, fsnp_pkg::PK_ZERO, 8);
        end
        default: buf_q.push_back(c);
      endcase
      fmt_phase = PH_SCAN;
      return;
    end
    if (c == fsnp_pkg::CH_PERCENT) begin
      fmt_phase = PH_FLAGS;
      fmt_pad = fsnp_pkg::PK_SPACE;
      fmt_width = 0;
    end else begin
      fmt_phase = PH_SCAN;
      buf_q.push_back(c);
    end
  endfunction

  task automatic queue_expected(input logic [7:0] buf_q[$]);
    foreach (buf_q[i]) expected_text.push_back('{buf_q[i], i == buf_q.size() - 1});
  endtask

  // send one item and return at the edge that accepts it; valid stays up for the next item
  task automatic send_item(input logic [7:0] c, input logic [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol <= c;
    arg_value <= a;
    // stall only moves at the rising edge, so look at it mid-cycle
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic apply(input logic [7:0] c, input logic [31:0] a, input string typed);
    logic [7:0] buf_q[$];
    format_symbol(c, a, buf_q);
    if (typed.len() != 0) begin
      if (typed.len() != buf_q.size()) report($sformatf("table text for %h disagrees", c));
      buf_q = {};
      for (int i = 0; i < typed.len(); i++) buf_q.push_back(typed[i]);
    end
    queue_expected(buf_q);
    send_item(c, a);
  endtask

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1, 2: return "%";
      3: return "d";
      4: return "x";
      5: return "u";
      6: return "p";
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h80000000;
      3: return 32'($urandom_range(999));
      default: return $urandom;
    endcase
  endfunction

  // one conversion with random flags, width and length, ended by d, u, x, p, % or q
  task automatic send_conversion(input bit wide);
    string conv;
    apply(fsnp_pkg::CH_PERCENT, $urandom, "");
    repeat ($urandom_range(2)) begin
      conv = "0- +";
      apply(conv[$urandom_range(3)], $urandom, "");
    end
    if ($urandom_range(1)) begin
      if (wide) apply(8'(fsnp_pkg::CH_ZERO + $urandom_range(4, 6)), $urandom, "");
      apply(8'(fsnp_pkg::CH_ZERO + $urandom_range(9)), $urandom, "");
    end
    if ($urandom_range(3) == 0) begin
      conv = "hlLjzt";
      apply(conv[$urandom_range(5)], $urandom, "");
    end
    conv = "duxp%duxq";
    apply(conv[$urandom_range(8)], pick_arg(), "");
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; ) begin
      if ($urandom_range(9) < 7) begin
        send_conversion($urandom_range(19) == 0);
        i += 3;
      end else begin
        apply(pick_symbol(), pick_arg(), "");
        i++;
      end
    end
  endtask

  stim_row_t directed[] = '{
    '{"A", 32'h0, "A"},
    '{8'h00, 32'h0, "\000"},
    '{8'hff, 32'h0, ""},
    '{"%", 32'h0, ""},
    '{"d", 32'h80000000, "-2147483648"},
    '{"%", 32'h0, ""},
    '{"u", 32'hffffffff, "4294967295"},
    '{"%", 32'h0, ""},
    '{"x", 32'hffffffff, "ffffffff"},
    '{"%", 32'h0, ""},
    '{"p", 32'h0, "0x00000000"},
    '{"%", 32'h0, ""},
    '{"%", 32'h0, "%"},
    '{"%", 32'h0, ""},
    '{"-", 32'h0, ""},
    '{"0", 32'h0, ""},
    '{"+", 32'h0, ""},
    '{" ", 32'h0, ""},
    '{"9", 32'h0, ""},
    '{"0", 32'h0, ""},
    '{"l", 32'h0, ""},
    '{"d", 32'hffffffff, ""},
    '{"%", 32'h0, ""},
    '{"q", 32'h0, "q"},
    '{"%", 32'h0, ""}
  };

  // output side: random stall and checking
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          report($sformatf("unexpected char %h", out_char));
        end else begin
          if (out_char !== expected_text[0].ch)
            report($sformatf("out_char %h, want %h", out_char, expected_text[0].ch));
          if (last !== expected_text[0].lst)
            report($sformatf("last %b, want %b", last, expected_text[0].lst));
          void'(expected_text.pop_front());
        end
      end
      out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on accepted items of either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) apply(directed[i].symbol, directed[i].arg, directed[i].text);
    apply("d", 32'h7fffffff, "");
    // back-pressure burst: receiver holds off while items keep coming
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      repeat (6) apply(pick_symbol(), pick_arg(), "");
    join
    send_idle_pct = 24; recv_idle_pct = 52;
    random_phase(160);
    send_idle_pct = 52; recv_idle_pct = 24;
    random_phase(160);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(160);
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_text.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
